[rtl/rttb_pkg.sv]
// rttb_pkg: types, codes and reset constants for the RTT estimator with
// retransmission timeout backoff. No dependencies; every rtl file imports it.
package rttb_pkg;

   // Field widths
   localparam int unsigned MsWidth    = 24;
   localparam int unsigned StateWidth = 26;
   localparam int unsigned CountWidth = 8;
   localparam int unsigned CsrIdxWidth = 2;

   // Reset values
   localparam logic [MsWidth-1:0]    MinTimeoutReset     = 24'd2000;
   localparam logic [MsWidth-1:0]    MaxTimeoutReset     = 24'd60000;
   localparam logic [CountWidth-1:0] MaxRetransmitsReset = 8'd3;
   localparam logic [StateWidth-1:0] DeviationReset      = 26'd750;
   // 0 + 4*750 lies inside the reset clamp window
   localparam logic [MsWidth-1:0]    TimeoutReset        = 24'd3000;

   // Event codes; code 3 is unused and leaves the state alone
   typedef enum logic [1:0] {
      MODE_NEW_PACKET = 2'd0,
      MODE_SAMPLE     = 2'd1,
      MODE_TIMEOUT    = 2'd2
   } mode_type;

   // Register indexes on the csr port
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_MIN_TIMEOUT     = 2'd0,
      CSR_MAX_TIMEOUT     = 2'd1,
      CSR_MAX_RETRANSMITS = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic [MsWidth-1:0] sample_ms;
   } req_type;

   typedef struct packed {
      logic [MsWidth-1:0] timeout_ms;
      logic               give_up;
   } rsp_type;

   typedef struct packed {
      logic [MsWidth-1:0]    min_timeout;
      logic [MsWidth-1:0]    max_timeout;
      logic [CountWidth-1:0] max_retransmits;
   } cfg_type;

   typedef struct packed {
      logic [StateWidth-1:0] smoothed_rtt;
      logic [StateWidth-1:0] rtt_deviation;
      logic [MsWidth-1:0]    current_timeout;
      logic [CountWidth-1:0] retransmit_count;
   } est_state_type;

endpackage

[rtl/rttb_csr.sv]
// rttb_csr: configuration registers (timeout clamps and retransmit limit).
// Depends on rttb_pkg.
module rttb_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [rttb_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [rttb_pkg::MsWidth-1:0]    csr_wdata,
   output rttb_pkg::cfg_type               cfg
);
   import rttb_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode one write per cycle; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MIN_TIMEOUT:     cfg_in.min_timeout     = csr_wdata;
            CSR_MAX_TIMEOUT:     cfg_in.max_timeout     = csr_wdata;
            CSR_MAX_RETRANSMITS: cfg_in.max_retransmits = csr_wdata[CountWidth-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_timeout     <= MinTimeoutReset;
         cfg_ff.max_timeout     <= MaxTimeoutReset;
         cfg_ff.max_retransmits <= MaxRetransmitsReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

[rtl/rttb_update.sv]
// rttb_update: combinational next-state and result for one event.
// Depends on rttb_pkg.
module rttb_update (
   input  rttb_pkg::req_type       req,
   input  rttb_pkg::cfg_type       cfg,
   input  rttb_pkg::est_state_type cur,
   output rttb_pkg::est_state_type nxt,
   output rttb_pkg::rsp_type       rsp
);
   import rttb_pkg::*;

   localparam int unsigned SW = StateWidth + 1;  // signed working width
   localparam int unsigned TW = StateWidth + 2;  // timeout candidate width

   // Clamp: below min gives min, else above max gives max
   function automatic logic [MsWidth-1:0] clamp_ms(input logic [TW-1:0] v,
                                                  input logic [MsWidth-1:0] lo,
                                                  input logic [MsWidth-1:0] hi);
      logic [MsWidth-1:0] res;
      if (v < TW'(lo))
         res = lo;
      else if (v > TW'(hi))
         res = hi;
      else
         res = v[MsWidth-1:0];
      return res;
   endfunction

   logic signed [SW-1:0] srtt_x, dev_x, sample_x;
   logic signed [SW-1:0] delta, mag, err;
   logic signed [SW-1:0] srtt_new, dev_new;
   logic [TW-1:0]        rto_sample, rto_double;
   logic [CountWidth-1:0] count_inc;

   // Sample path: ceil(delta/8) and ceil(err/4) via bias then arithmetic shift
   always_comb begin
      srtt_x   = $signed({1'b0, cur.smoothed_rtt});
      dev_x    = $signed({1'b0, cur.rtt_deviation});
      sample_x = $signed({{(SW-MsWidth){1'b0}}, req.sample_ms});
      delta    = sample_x - srtt_x;
      srtt_new = srtt_x + ((delta + SW'(7)) >>> 3);
      mag      = delta[SW-1] ? -delta : delta;
      err      = mag - dev_x;
      dev_new  = dev_x + ((err + SW'(3)) >>> 2);
      rto_sample = {2'b00, srtt_new[StateWidth-1:0]}
                 + {dev_new[StateWidth-1:0], 2'b00};
   end

   // Timeout path: double and saturating count
   assign rto_double = {{(TW-MsWidth-1){1'b0}}, cur.current_timeout, 1'b0};
   assign count_inc  = (cur.retransmit_count == {CountWidth{1'b1}}) ?
                       cur.retransmit_count : cur.retransmit_count + 1'b1;

   // Select by event kind
   always_comb begin
      nxt         = cur;
      rsp.give_up = 1'b0;
      case (req.mode)
         MODE_NEW_PACKET: begin
            nxt.retransmit_count = '0;
         end
         MODE_SAMPLE: begin
            nxt.smoothed_rtt    = srtt_new[StateWidth-1:0];
            nxt.rtt_deviation   = dev_new[StateWidth-1:0];
            nxt.current_timeout = clamp_ms(rto_sample, cfg.min_timeout, cfg.max_timeout);
         end
         MODE_TIMEOUT: begin
            nxt.current_timeout  = clamp_ms(rto_double, cfg.min_timeout, cfg.max_timeout);
            nxt.retransmit_count = count_inc;
            rsp.give_up          = (count_inc > cfg.max_retransmits);
         end
         default: begin
            nxt = cur;
         end
      endcase
      rsp.timeout_ms = nxt.current_timeout;
   end
endmodule

[rtl/rtt_estimator_rto_backoff.sv]
// rtt_estimator_rto_backoff: top level; request register, estimator state,
// result register. Depends on rttb_pkg, rttb_csr and rttb_update.
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_ready  rttb_pkg::req_type (mode, sample_ms)
//  rsp      out        rsp_valid/rsp_ready  rttb_pkg::rsp_type (timeout_ms, give_up)
//  csr      in         csr_we (no wait)     csr_index, csr_wdata
//
// rsp_valid rises once an accepted request has passed the request register and
// then the result register; one request per cycle is sustained while rsp_ready
// is high, as the state update in rttb_update is combinational.
// Synchronous reset clears valids, state and config registers to their reset values.
// A stalled result holds the request register; req_ready drops only when both
// the request register and the result register are full and rsp_ready is low.
module rtt_estimator_rto_backoff (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  rttb_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output rttb_pkg::rsp_type                rsp_data,
   input  logic                             csr_we,
   input  logic [rttb_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [rttb_pkg::MsWidth-1:0]     csr_wdata
);
   import rttb_pkg::*;

   cfg_type       cfg;
   req_type       req_ff;
   logic          req_valid_ff;
   est_state_type state_ff, state_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff;
   logic          advance;

   rttb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rttb_update u_update (
      .req (req_ff),
      .cfg (cfg),
      .cur (state_ff),
      .nxt (state_in),
      .rsp (rsp_in)
   );

   // Handshake: the request register moves on whenever the result slot frees
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;

   // Request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         req_ff <= req_data;
      end
   end

   // Estimator state, updated once per request
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.smoothed_rtt     <= '0;
         state_ff.rtt_deviation    <= DeviationReset;
         state_ff.current_timeout  <= TimeoutReset;
         state_ff.retransmit_count <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   a_giveup_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.give_up |-> state_ff.retransmit_count > cfg.max_retransmits)
      else $error("give_up without retransmit count above limit");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("request taken while pipeline full and stalled");

   a_advance_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced request produced no result");

   a_hold_state: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("estimator state changed without a request");
endmodule
